// ----- rtl/mm4_pkg.sv -----
`default_nettype none

package mm4_pkg;

	// element width of the stream payload, Q format is set by FRAC_BITS
	localparam int ELEM_W = 32;
	localparam int PROD_W = 2 * ELEM_W;

	// two matrix banks: one fills while the other is multiplied
	localparam int QUEUE_DEPTH = 2;

	// saturation limits of a product element
	localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	// a loaded matrix pair waiting to be multiplied
	typedef struct packed {
		logic valid;
		logic bank;
	} mm4_job_t;

endpackage

`default_nettype wire

// ----- rtl/mm4_ram.sv -----
`default_nettype none

module mm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/mm4_front.sv -----
`default_nettype none

module mm4_front #(
	parameter int MATRIX_DIM = 4,
	parameter int IDX_W      = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [2*mm4_pkg::ELEM_W-1:0] s_tdata,
	input  wire logic                       queue_full,
	output mm4_pkg::mm4_job_t               push_job,
	output logic                            wr_en,
	output logic      [IDX_W:0]             wr_addr,
	output logic      [mm4_pkg::ELEM_W-1:0] wr_left,
	output logic      [mm4_pkg::ELEM_W-1:0] wr_right
);

	import mm4_pkg::*;

	localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;

	logic [IDX_W-1:0] load_cnt_q;
	logic             bank_q;
	logic             xfer;
	logic             cnt_last;

	// a free bank exists whenever the job queue has room
	assign s_tready = !queue_full;
	assign xfer     = s_tvalid && s_tready;
	assign cnt_last = (load_cnt_q == IDX_W'(ELEMS - 1));

	// store the pair into the bank being filled
	assign wr_en    = xfer;
	assign wr_addr  = {bank_q, load_cnt_q};
	assign wr_left  = s_tdata[ELEM_W-1:0];
	assign wr_right = s_tdata[2*ELEM_W-1:ELEM_W];

	// a full matrix pair becomes a job
	assign push_job.valid = xfer && cnt_last;
	assign push_job.bank  = bank_q;

	// load position and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			bank_q     <= 1'b0;
		end else if (xfer) begin
			if (cnt_last) begin
				load_cnt_q <= '0;
				bank_q     <= !bank_q;
			end else begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mm4_queue.sv -----
`default_nettype none

module mm4_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mm4_pkg::mm4_job_t push_job,
	input  wire logic              pop,
	output logic                   full,
	output mm4_pkg::mm4_job_t      head_job
);

	import mm4_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full           = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_job.valid = (count_q != '0);
	assign head_job.bank  = slot_q[rd_ptr_q];

	// token slots
	always_ff @(posedge clk) begin
		if (push_job.valid) begin
			slot_q[wr_ptr_q] <= push_job.bank;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_job.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_job.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mm4_back.sv -----
`default_nettype none

module mm4_back #(
	parameter int MATRIX_DIM = 4,
	parameter int FRAC_BITS  = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mm4_pkg::mm4_job_t          head_job,
	output logic                            pop,
	output logic                            rd_en,
	output logic      [IDX_W:0]             rd_left_addr,
	output logic      [IDX_W:0]             rd_right_addr,
	input  wire logic [mm4_pkg::ELEM_W-1:0] rd_left,
	input  wire logic [mm4_pkg::ELEM_W-1:0] rd_right,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [mm4_pkg::ELEM_W-1:0] m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);

	import mm4_pkg::*;

	localparam int DIM_W = $clog2(MATRIX_DIM);
	localparam int ACC_W = PROD_W + DIM_W + 1;

	// position of the next term
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] term_q;
	logic             row_end;
	logic             col_end;
	logic             term_end;
	logic             adv;
	logic             issue;

	// stage flags and data
	logic                     vld_s1, first_s1, lastj_s1, lastel_s1;
	logic                     vld_s2, first_s2, lastj_s2, lastel_s2;
	logic                     done_s3, lastel_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] term;
	logic signed [ACC_W-1:0]  term_ext;
	logic signed [ACC_W-1:0]  acc_q;

	// saturation
	logic             in_range;
	logic [ELEM_W-1:0] sat_val;

	logic              out_valid_q;
	logic [ELEM_W-1:0] out_data_q;
	logic              out_sat_q;
	logic              out_last_q;

	// whole pipeline moves unless a result waits at the output
	assign adv   = !out_valid_q || m_tready;
	assign issue = head_job.valid && adv;

	assign term_end = (term_q == DIM_W'(MATRIX_DIM - 1));
	assign col_end  = (col_q == DIM_W'(MATRIX_DIM - 1));
	assign row_end  = (row_q == DIM_W'(MATRIX_DIM - 1));

	// bank is released once its final read is issued
	assign pop   = issue && term_end && col_end && row_end;
	assign rd_en = issue;

	assign rd_left_addr  = {head_job.bank,
		IDX_W'(32'(row_q) * MATRIX_DIM + 32'(term_q))};
	assign rd_right_addr = {head_job.bank,
		IDX_W'(32'(term_q) * MATRIX_DIM + 32'(col_q))};

	// term, column, row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			term_q <= '0;
		end else if (issue) begin
			if (term_end) begin
				term_q <= '0;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				term_q <= term_q + 1'b1;
			end
		end
	end

	// stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			first_s1  <= 1'b0;
			lastj_s1  <= 1'b0;
			lastel_s1 <= 1'b0;
			vld_s2    <= 1'b0;
			first_s2  <= 1'b0;
			lastj_s2  <= 1'b0;
			lastel_s2 <= 1'b0;
			done_s3   <= 1'b0;
			lastel_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1    <= issue;
			first_s1  <= (term_q == '0);
			lastj_s1  <= term_end;
			lastel_s1 <= col_end && row_end;
			vld_s2    <= vld_s1;
			first_s2  <= first_s1;
			lastj_s2  <= lastj_s1;
			lastel_s2 <= lastel_s1;
			done_s3   <= vld_s2 && lastj_s2;
			lastel_s3 <= lastel_s2;
		end
	end

	// floor-scaled term, sign extended to the accumulator
	assign term     = prod_s2 >>> FRAC_BITS;
	assign term_ext = {{(ACC_W-PROD_W){term[PROD_W-1]}}, term};

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(rd_left) * $signed(rd_right);
			if (vld_s2) begin
				acc_q <= first_s2 ? term_ext : acc_q + term_ext;
			end
		end
	end

	// clip the finished sum to 32 bits
	assign in_range = (acc_q[ACC_W-1:ELEM_W-1] == '0) ||
		(acc_q[ACC_W-1:ELEM_W-1] == '1);
	assign sat_val  = acc_q[ACC_W-1] ? ELEM_MIN : ELEM_MAX;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done_s3) begin
			out_data_q <= in_range ? acc_q[ELEM_W-1:0] : sat_val;
			out_sat_q  <= !in_range;
			out_last_q <= lastel_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply_4x4.sv -----
`default_nettype none

// channel  dir  tdata                                   tuser       tlast
// s        in   [31:0] left_element, [63:32] right_elem  -           -
// m        out  [31:0] product_element                   saturated   is_last
//
// A matrix pair loads in MATRIX_DIM^2 transfers, one per cycle while s_tready
// is high, into one of two banks. The multiply-accumulate unit then works one
// term per cycle, unless the output stalls, through a single 32x32 multiplier;
// a term passes the bank read, product, accumulator and output registers.
// Loading of the next pair overlaps the multiply; s_tready drops only while
// both banks hold pairs not yet multiplied. Output stalls freeze the multiply
// pipeline. Reset clears the counters and queue; the banks need no clearing.

module matrix_multiply_4x4 #(
	parameter int MATRIX_DIM = 4,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] left_element, [63:32] right_element
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] product_element
	output logic             m_tuser,   // [0] saturated
	output logic             m_tlast
);

	import mm4_pkg::*;

	localparam int IDX_W = $clog2(MATRIX_DIM * MATRIX_DIM);
	localparam int DEPTH = 2 ** (IDX_W + 1);

	mm4_job_t          push_job;
	mm4_job_t          head_job;
	logic              queue_full;
	logic              pop;
	logic              wr_en;
	logic [IDX_W:0]    wr_addr;
	logic [ELEM_W-1:0] wr_left;
	logic [ELEM_W-1:0] wr_right;
	logic              rd_en;
	logic [IDX_W:0]    rd_left_addr;
	logic [IDX_W:0]    rd_right_addr;
	logic [ELEM_W-1:0] rd_left;
	logic [ELEM_W-1:0] rd_right;

	// load side
	mm4_front #(
		.MATRIX_DIM (MATRIX_DIM),
		.IDX_W      (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (queue_full),
		.push_job   (push_job),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_left    (wr_left),
		.wr_right   (wr_right)
	);

	// matrix banks
	mm4_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_left_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_left),
		.rd_en   (rd_en),
		.rd_addr (rd_left_addr),
		.rd_data (rd_left)
	);

	mm4_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_right_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_right),
		.rd_en   (rd_en),
		.rd_addr (rd_right_addr),
		.rd_data (rd_right)
	);

	// loaded pairs waiting for the multiplier
	mm4_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_job (push_job),
		.pop      (pop),
		.full     (queue_full),
		.head_job (head_job)
	);

	// multiply-accumulate side
	mm4_back #(
		.MATRIX_DIM (MATRIX_DIM),
		.FRAC_BITS  (FRAC_BITS),
		.IDX_W      (IDX_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_job      (head_job),
		.pop           (pop),
		.rd_en         (rd_en),
		.rd_left_addr  (rd_left_addr),
		.rd_right_addr (rd_right_addr),
		.rd_left       (rd_left),
		.rd_right      (rd_right),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

endmodule

`default_nettype wire
